@@ rtl/ufe_pkg.sv @@
// Shared types and constants for the union-find engine.
package ufe_pkg;

  localparam int unsigned NODES  = 1024;
  localparam int unsigned NODE_W = $clog2(NODES);
  localparam int unsigned SIZE_W = 11;
  localparam int unsigned RANK_W = 4;

  localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};
  localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};

  typedef enum logic {
    CMD_FIND  = 1'b0,
    CMD_UNION = 1'b1
  } ufe_cmd_e;

  typedef enum logic {
    POLICY_SIZE = 1'b0,
    POLICY_RANK = 1'b1
  } ufe_policy_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_COMPRESS,
    S_RESOLVE,
    S_LINK,
    S_OUT
  } ufe_state_e;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [SIZE_W-1:0] size;
    logic [NODE_W-1:0] parent;
  } ufe_entry_t;

endpackage

@@ rtl/union_find_engine.sv @@
// Union-find engine top level: node table memory, walk sequencer and stream ports.
//
// Disjoint-set table over ufe_pkg::NODES nodes, each entry holding parent, set size and rank
// in one single-port-read, single-port-write memory with a registered read port. After
// reset the block runs a clearing pass over all NODES (1024) entries with s_axis_tready low;
// configuration writes are taken during it. A find walks the parent hops to the root, then
// repoints each path node at the root; each hop and each repoint is one memory access.
// A union runs two finds back to back and links the two roots when they differ, with an
// extra link state when the link touches two entries (size policy, or rank policy on a
// tie). One command is in flight at a time; the result register lets the next command
// start while a result waits on m_axis.
module union_find_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wen_i,
  input  logic        cfg_wdata_i,     // union_policy
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,    // node_a [9:0], node_b [19:10], zero [23:20]
  input  logic        s_axis_tuser,    // command [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,    // root [9:0], set_size [20:10], zero [23:21]
  output logic        m_axis_tuser     // already_joined [0]
);
  import ufe_pkg::*;

  ufe_state_e state_q, state_d;

  ufe_entry_t mem_q [NODES];
  ufe_entry_t rdata_q;
  logic              mem_re, mem_we;
  logic [NODE_W-1:0] mem_raddr, mem_waddr;
  ufe_entry_t        mem_wdata;

  ufe_policy_e policy_q;
  ufe_cmd_e    cmd_q;
  logic        phase_q;
  logic [NODE_W-1:0] clr_q, cur_q, start_q, node_b_q, fr_q;
  logic [NODE_W-1:0] ra_q, rb_q;
  logic [SIZE_W-1:0] sa_q, sb_q;
  logic [RANK_W-1:0] rka_q, rkb_q;

  logic [NODE_W-1:0] res_root_q;
  logic [SIZE_W-1:0] res_size_q;
  logic              res_join_q;
  logic [NODE_W-1:0] w2_addr_q;
  ufe_entry_t        w2_data_q;

  logic              out_valid_q, out_join_q;
  logic [NODE_W-1:0] out_root_q;
  logic [SIZE_W-1:0] out_size_q;

  logic [NODE_W-1:0] in_a, in_b;
  logic [SIZE_W:0]   size_sum;
  logic [SIZE_W-1:0] size_sat;
  logic [RANK_W-1:0] rank_inc;
  logic [NODE_W-1:0] l0_addr, l1_addr, l_root;
  ufe_entry_t        l0_data, l1_data;
  logic              l1_en;
  logic [SIZE_W-1:0] l_size;
  logic              out_free, is_union, same_root;

  assign in_a     = s_axis_tdata[NODE_W-1:0];
  assign in_b     = s_axis_tdata[10+NODE_W-1:10];
  assign out_free = !out_valid_q || m_axis_tready;
  assign is_union = (cmd_q == CMD_UNION);
  assign same_root = (ra_q == rb_q);

  // link decision
  assign size_sum = {1'b0, sa_q} + {1'b0, sb_q};
  assign size_sat = size_sum[SIZE_W] ? SIZE_MAX : size_sum[SIZE_W-1:0];
  assign rank_inc = (rka_q == RANK_MAX) ? rka_q : rka_q + RANK_W'(1);

  always_comb begin
    l0_addr = rb_q;
    l0_data = '{rank: rkb_q, size: sb_q, parent: ra_q};
    l1_addr = ra_q;
    l1_data = '{rank: rka_q, size: size_sat, parent: ra_q};
    l1_en   = 1'b1;
    l_root  = ra_q;
    l_size  = size_sat;
    if (policy_q == POLICY_SIZE) begin
      if (sa_q < sb_q) begin
        l0_addr = ra_q;
        l0_data = '{rank: rka_q, size: sa_q, parent: rb_q};
        l1_addr = rb_q;
        l1_data = '{rank: rkb_q, size: size_sat, parent: rb_q};
        l_root  = rb_q;
      end
    end else begin
      if (rka_q < rkb_q) begin
        l0_addr = ra_q;
        l0_data = '{rank: rka_q, size: sa_q, parent: rb_q};
        l1_en   = 1'b0;
        l_root  = rb_q;
        l_size  = sb_q;
      end else if (rkb_q < rka_q) begin
        l1_en   = 1'b0;
        l_size  = sa_q;
      end else begin
        l1_data = '{rank: rank_inc, size: sa_q, parent: ra_q};
        l_size  = sa_q;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == NODE_W'(NODES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid) state_d = S_WALK;
      end
      S_WALK: begin
        if (rdata_q.parent == cur_q) begin
          state_d = (start_q != cur_q) ? S_COMPRESS : S_RESOLVE;
        end
      end
      S_COMPRESS: begin
        if (rdata_q.parent == fr_q) state_d = S_RESOLVE;
      end
      S_RESOLVE: begin
        if (is_union && !phase_q) state_d = S_WALK;
        else if (is_union && !same_root && l1_en) state_d = S_LINK;
        else state_d = S_OUT;
      end
      S_LINK: state_d = S_OUT;
      S_OUT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // memory controls and input handshake
  always_comb begin
    s_axis_tready = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = cur_q;
    mem_we    = 1'b0;
    mem_waddr = cur_q;
    mem_wdata = rdata_q;
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '{rank: '0, size: SIZE_W'(1), parent: clr_q};
      end
      S_IDLE: begin
        s_axis_tready = 1'b1;
        mem_re    = s_axis_tvalid;
        mem_raddr = in_a;
      end
      S_WALK: begin
        if (rdata_q.parent != cur_q) begin
          mem_re    = 1'b1;
          mem_raddr = rdata_q.parent;
        end else if (start_q != cur_q) begin
          mem_re    = 1'b1;
          mem_raddr = start_q;
        end
      end
      S_COMPRESS: begin
        mem_we    = 1'b1;
        mem_waddr = cur_q;
        mem_wdata = '{rank: rdata_q.rank, size: rdata_q.size, parent: fr_q};
        if (rdata_q.parent != fr_q) begin
          mem_re    = 1'b1;
          mem_raddr = rdata_q.parent;
        end
      end
      S_RESOLVE: begin
        if (is_union && !phase_q) begin
          mem_re    = 1'b1;
          mem_raddr = node_b_q;
        end else if (is_union && !same_root) begin
          mem_we    = 1'b1;
          mem_waddr = l0_addr;
          mem_wdata = l0_data;
        end
      end
      S_LINK: begin
        mem_we    = 1'b1;
        mem_waddr = w2_addr_q;
        mem_wdata = w2_data_q;
      end
      S_OUT: ;
      default: ;
    endcase
  end

  // node table
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      policy_q <= POLICY_SIZE;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + NODE_W'(1);
      if (cfg_wen_i) policy_q <= ufe_policy_e'(cfg_wdata_i);
    end
  end

  // walk datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_q    <= ufe_cmd_e'(s_axis_tuser);
          cur_q    <= in_a;
          start_q  <= in_a;
          node_b_q <= in_b;
          phase_q  <= 1'b0;
        end
      end
      S_WALK: begin
        if (rdata_q.parent != cur_q) begin
          cur_q <= rdata_q.parent;
        end else begin
          fr_q <= cur_q;
          if (!phase_q) begin
            ra_q  <= cur_q;
            sa_q  <= rdata_q.size;
            rka_q <= rdata_q.rank;
          end else begin
            rb_q  <= cur_q;
            sb_q  <= rdata_q.size;
            rkb_q <= rdata_q.rank;
          end
          cur_q <= start_q;
        end
      end
      S_COMPRESS: cur_q <= rdata_q.parent;
      S_RESOLVE: begin
        if (!is_union) begin
          res_root_q <= ra_q;
          res_size_q <= sa_q;
          res_join_q <= 1'b0;
        end else if (!phase_q) begin
          phase_q <= 1'b1;
          cur_q   <= node_b_q;
          start_q <= node_b_q;
        end else if (same_root) begin
          res_root_q <= ra_q;
          res_size_q <= sa_q;
          res_join_q <= 1'b1;
        end else begin
          res_root_q <= l_root;
          res_size_q <= l_size;
          res_join_q <= 1'b0;
          w2_addr_q  <= l1_addr;
          w2_data_q  <= l1_data;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_root_q <= res_root_q;
      out_size_q <= res_size_q;
      out_join_q <= res_join_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_size_q, out_root_q};
  assign m_axis_tuser  = out_join_q;

  // checks
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re && (mem_waddr == mem_raddr)))
    else $error("read and write of one table entry in the same cycle");

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !s_axis_tready)
    else $error("input taken during clearing pass");

  a_beat_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result beat raised outside the result state");

  a_size_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_size_q != '0))
    else $error("result carries a zero set size");

endmodule
